[hdl/csv_stream_parser_top_assert.svh]
// assertion macros shared by the csv parser checker
`ifndef CSV_STREAM_PARSER_TOP_ASSERT_SVH
`define CSV_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csv parser assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define CSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csv parser assertion failed");

`endif

[hdl/csp_pkg.sv]
// types, codes and characters shared by the csv stream parser
package csp_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] PH_ROW      = 3'd0;
  localparam logic [2:0] PH_FIELD    = 3'd1;
  localparam logic [2:0] PH_PLAIN    = 3'd2;
  localparam logic [2:0] PH_QUOTED   = 3'd3;
  localparam logic [2:0] PH_QPEND    = 3'd4;
  localparam logic [2:0] PH_AFTER_CR = 3'd5;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_FEND  = 2'd1;
  localparam logic [1:0] KIND_REND  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } csp_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] field_byte;
    logic       last_of_run;
  } csp_out_t;

  // results produced by one item, handed from decode to the queue
  typedef struct packed {
    logic [1:0] count;
    csp_out_t   first;
    csp_out_t   second;
  } csp_dec_t;

endpackage

[hdl/csp_decode.sv]
// next parse phase and result items for one input item
module csp_decode import csp_pkg::*; (
  input  logic [2:0] phase,
  input  csp_in_t    item,
  output logic [2:0] phase_next,
  output csp_dec_t   dec
);

  logic [2:0] ph;
  logic [7:0] b;
  logic       eol;
  logic       at_row;
  logic [1:0] k0;
  logic [1:0] k1;
  logic [1:0] n;

  assign ph     = (phase > PH_AFTER_CR) ? PH_ROW : phase;
  assign b      = item.text_byte;
  assign eol    = b inside {CH_CR, CH_LF};
  assign at_row = (ph != PH_FIELD);

  always_comb begin
    phase_next = ph;
    k0 = KIND_BYTE;
    k1 = KIND_BYTE;
    n  = 2'd0;
    if (item.is_end) begin
      if (ph != PH_ROW && ph != PH_AFTER_CR) begin
        k0 = KIND_REND;
        n  = 2'd1;
      end
      phase_next = PH_ROW;
    end else begin
      case (ph)
        PH_QUOTED: begin
          if (b == CH_QUOTE) begin
            phase_next = PH_QPEND;
          end else begin
            n = 2'd1;
          end
        end
        PH_QPEND: begin
          n = 2'd1;
          if (b == CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if (b == CH_COMMA) begin
            k0 = KIND_FEND;
            phase_next = PH_FIELD;
          end else if (eol) begin
            k0 = KIND_REND;
            phase_next = (b == CH_CR) ? PH_AFTER_CR : PH_ROW;
          end else begin
            k0 = KIND_FEND;
            n  = 2'd2;
            phase_next = PH_PLAIN;
          end
        end
        PH_PLAIN: begin
          n = 2'd1;
          if (b == CH_COMMA) begin
            k0 = KIND_FEND;
            phase_next = PH_FIELD;
          end else if (eol) begin
            k0 = KIND_REND;
            phase_next = (b == CH_CR) ? PH_AFTER_CR : PH_ROW;
          end
        end
        default: begin
          // row start, after cr, or field start after a comma
          if (ph == PH_AFTER_CR && b == CH_LF) begin
            phase_next = PH_ROW;
          end else if (b == CH_QUOTE) begin
            phase_next = PH_QUOTED;
          end else if (b == CH_COMMA) begin
            k0 = KIND_FEND;
            n  = 2'd1;
            phase_next = PH_FIELD;
          end else if (eol) begin
            k0 = at_row ? KIND_EMPTY : KIND_REND;
            n  = 2'd1;
            phase_next = (b == CH_CR) ? PH_AFTER_CR : PH_ROW;
          end else begin
            n = 2'd1;
            phase_next = PH_PLAIN;
          end
        end
      endcase
    end
  end

  always_comb begin
    dec.count              = n;
    dec.first.kind         = k0;
    dec.first.field_byte   = (k0 == KIND_BYTE) ? b : 8'd0;
    dec.first.last_of_run  = (n == 2'd1);
    dec.second.kind        = k1;
    dec.second.field_byte  = (k1 == KIND_BYTE) ? b : 8'd0;
    dec.second.last_of_run = 1'b1;
  end

endmodule

[hdl/csp_outq.sv]
// small result queue, takes up to two items per cycle, gives one
module csp_outq import csp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  csp_dec_t dec,
  output logic     room,
  output logic     result_valid,
  input  logic     result_ready,
  output csp_out_t result_item
);

  csp_out_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic [QUEUE_AW:0]     count_next;
  logic [1:0]            push_n;
  logic                  pop;

  assign push_n       = push ? dec.count : 2'd0;
  assign pop          = result_valid && result_ready;
  assign result_valid = (count != '0);
  assign result_item  = mem[rd_ptr];
  // room for the worst case of two items from the next input
  assign room         = (count <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign count_next   = count + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QUEUE_AW'(push_n);
      rd_ptr <= rd_ptr + QUEUE_AW'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= dec.first;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + QUEUE_AW'(1)] <= dec.second;
    end
  end

endmodule

[hdl/csv_stream_parser_top.sv]
// a result item is registered in the result queue, behind any results waiting there
// throughput: one input item per cycle while the consumer keeps up; an item
//   giving two results (byte right after a closing quote) leaves one extra
//   result, absorbed by the four-entry result queue
// reset: rst is synchronous, active high; clears the parse phase to row start
//   and empties the result queue
module csv_stream_parser_top import csp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_ready,
  input  csp_in_t  byte_item,
  output logic     result_valid,
  input  logic     result_ready,
  output csp_out_t result_item
);

  // parser phase register, the only state the parse needs
  logic [2:0] phase;
  logic [2:0] phase_next;
  csp_dec_t   dec;
  logic       accept;
  logic       room;

  // an item is taken whenever the queue can hold both of its possible results,
  // regardless of whether the consumer is stalled right now
  assign byte_ready = room;
  assign accept     = byte_valid && byte_ready;

  // pure decode of one byte against the current phase
  csp_decode u_decode (
    .phase      (phase),
    .item       (byte_item),
    .phase_next (phase_next),
    .dec        (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ROW;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // results are registered in the queue, which also parts the two handshakes
  csp_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .dec          (dec),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

[hdl/csp_checker.sv]
// port-level checks for the csv stream parser, bound to the top level
`include "csv_stream_parser_top_assert.svh"

module csp_checker import csp_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     byte_valid,
  input logic     byte_ready,
  input csp_in_t  byte_item,
  input logic     result_valid,
  input logic     result_ready,
  input csp_out_t result_item
);

  logic plain_byte;

  assign plain_byte = !byte_item.is_end && byte_item.text_byte != CH_COMMA &&
                      byte_item.text_byte != CH_QUOTE && byte_item.text_byte != CH_CR &&
                      byte_item.text_byte != CH_LF;

  // non-content results carry a zero byte
  `CSP_ASSERT_NOW(a_zero_byte, result_valid && result_item.kind != KIND_BYTE,
    result_item.field_byte == 8'd0)

  // an ordinary byte always yields at least one result, visible next cycle
  `CSP_ASSERT_NEXT(a_plain_gives_result, byte_valid && byte_ready && plain_byte,
    result_valid)

  // nothing is offered right after reset
  `CSP_ASSERT_NOW(a_empty_after_reset, $past(rst), !result_valid)

  // a stalled result holds
  `CSP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
    result_valid && $stable(result_item))

endmodule

bind csv_stream_parser_top csp_checker u_csp_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_item    (byte_item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_item  (result_item)
);
